[hw/rtl/blake2b_hash_engine_assert.svh]
// Assertion macros shared by the BLAKE2b engine modules.
// Needs a clock i_clk and an active-low reset i_rst_n in the including module.
`ifndef BLAKE2B_HASH_ENGINE_ASSERT_SVH
`define BLAKE2B_HASH_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
// check a property outside reset
`define BLK2_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// check a property at every edge, reset included
`define BLK2_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define BLK2_ASSERT(lbl, prop, msg)
`define BLK2_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/blk2_pkg.sv]
// Package for the BLAKE2b engine: item type, IV, permutation and mixing tables.
// No dependencies.
`timescale 1ns / 1ps
package blk2_pkg;
    localparam int QUEUE_DEPTH = 4;
    localparam int STEP_COUNT  = 192;  // 12 rounds x 8 mixes x 2 halves
    localparam logic FUNC_ABSORB = 1'b0;
    localparam logic FUNC_FINISH = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] data_byte;
    } t_item;

    localparam logic [0:7][63:0] IV = {
        64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
        64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
        64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
        64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
    };

    localparam logic [63:0] PARAM_BASE = 64'h0000000001010000;
    localparam logic [63:0] FINAL_MASK = 64'hFFFFFFFFFFFFFFFF;

    localparam logic [0:9][0:15][3:0] SIGMA = {
        {4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6, 4'd7,
         4'd8, 4'd9, 4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
        {4'd14,4'd10,4'd4, 4'd8, 4'd9, 4'd15,4'd13,4'd6,
         4'd1, 4'd12,4'd0, 4'd2, 4'd11,4'd7, 4'd5, 4'd3},
        {4'd11,4'd8, 4'd12,4'd0, 4'd5, 4'd2, 4'd15,4'd13,
         4'd10,4'd14,4'd3, 4'd6, 4'd7, 4'd1, 4'd9, 4'd4},
        {4'd7, 4'd9, 4'd3, 4'd1, 4'd13,4'd12,4'd11,4'd14,
         4'd2, 4'd6, 4'd5, 4'd10,4'd4, 4'd0, 4'd15,4'd8},
        {4'd9, 4'd0, 4'd5, 4'd7, 4'd2, 4'd4, 4'd10,4'd15,
         4'd14,4'd1, 4'd11,4'd12,4'd6, 4'd8, 4'd3, 4'd13},
        {4'd2, 4'd12,4'd6, 4'd10,4'd0, 4'd11,4'd8, 4'd3,
         4'd4, 4'd13,4'd7, 4'd5, 4'd15,4'd14,4'd1, 4'd9},
        {4'd12,4'd5, 4'd1, 4'd15,4'd14,4'd13,4'd4, 4'd10,
         4'd0, 4'd7, 4'd6, 4'd3, 4'd9, 4'd2, 4'd8, 4'd11},
        {4'd13,4'd11,4'd7, 4'd14,4'd12,4'd1, 4'd3, 4'd9,
         4'd5, 4'd0, 4'd15,4'd4, 4'd8, 4'd6, 4'd2, 4'd10},
        {4'd6, 4'd15,4'd14,4'd9, 4'd11,4'd3, 4'd0, 4'd8,
         4'd12,4'd2, 4'd13,4'd7, 4'd1, 4'd4, 4'd10,4'd5},
        {4'd10,4'd2, 4'd8, 4'd4, 4'd7, 4'd6, 4'd1, 4'd5,
         4'd15,4'd11,4'd9, 4'd14,4'd3, 4'd12,4'd13,4'd0}
    };

    localparam logic [0:7][0:3][3:0] MIX_POS = {
        {4'd0, 4'd4, 4'd8, 4'd12}, {4'd1, 4'd5, 4'd9, 4'd13},
        {4'd2, 4'd6, 4'd10,4'd14}, {4'd3, 4'd7, 4'd11,4'd15},
        {4'd0, 4'd5, 4'd10,4'd15}, {4'd1, 4'd6, 4'd11,4'd12},
        {4'd2, 4'd7, 4'd8, 4'd13}, {4'd3, 4'd4, 4'd9, 4'd14}
    };
endpackage

[hw/rtl/blk2_front.sv]
// Front queue of the BLAKE2b engine: accepts items and holds them for the core.
// Depends on blk2_pkg and blake2b_hash_engine_assert.svh.
`timescale 1ns / 1ps
`include "blake2b_hash_engine_assert.svh"
module blk2_front #(
    parameter int DEPTH = blk2_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic           i_func,
    input  logic [7:0]     i_data_byte,
    output blk2_pkg::t_item o_item,
    output logic           o_item_valid,
    input  logic           i_item_pop
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    blk2_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_cnt;
    logic push, pop;

    assign o_ready      = (r_cnt != FULL_CNT);
    assign o_item_valid = (r_cnt != '0);
    assign o_item       = r_mem[r_rd];
    assign push = i_valid && o_ready;
    assign pop  = i_item_pop && o_item_valid;

    // store pushed item
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= '{func: i_func, data_byte: i_data_byte};
        end
    end

    // advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            if (pop)  r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            if (push && !pop)      r_cnt <= r_cnt + 1'b1;
            else if (pop && !push) r_cnt <= r_cnt - 1'b1;
        end
    end

    `BLK2_ASSERT(a_cnt_bound, r_cnt <= FULL_CNT, "queue count above depth")
    `BLK2_ASSERT(a_pop_nonempty, i_item_pop |-> o_item_valid, "pop of empty queue")
    `BLK2_ASSERT(a_ptr_sync, (r_cnt == '0) |-> (r_wr == r_rd), "pointers out of step")
endmodule

[hw/rtl/blk2_core.sv]
// Back part of the BLAKE2b engine: block buffer, compression, digest output.
// Depends on blk2_pkg and blake2b_hash_engine_assert.svh.
`timescale 1ns / 1ps
`include "blake2b_hash_engine_assert.svh"
module blk2_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [1:0]      i_cfg_index,
    input  logic [6:0]      i_cfg_data,
    input  blk2_pkg::t_item i_item,
    input  logic            i_item_valid,
    output logic            o_item_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_digest_byte,
    output logic [5:0]      o_byte_index,
    output logic            o_last_byte
);
    localparam logic [1:0] CFG_DIGEST_LENGTH = 2'd0;
    localparam logic [1:0] CFG_KEY_LENGTH    = 2'd1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_INIT = 3'd1;
    localparam logic [2:0] ST_COMP = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    localparam logic [7:0] BLOCK_BYTES = 8'd128;
    localparam logic [7:0] LAST_STEP   = 8'(blk2_pkg::STEP_COUNT - 1);

    logic [2:0]   r_state;
    logic [6:0]   r_dl, r_kl;
    logic [63:0]  r_h [8];
    logic [63:0]  r_v [16];
    logic [63:0]  r_buf [16];
    logic [127:0] r_cnt;
    logic [7:0]   r_fill;
    logic [7:0]   r_step;
    logic         r_final;
    logic [7:0]   r_pend;
    logic [5:0]   r_eidx;
    logic         r_ov;
    logic [7:0]   r_obyte;
    logic [5:0]   r_oidx;
    logic         r_olast;

    // configuration as it will stand after this edge
    logic [6:0] n_dl, n_kl, ed, ek;
    logic [63:0] param;
    logic cfg_hit;
    always_comb begin
        n_dl = r_dl;
        n_kl = r_kl;
        cfg_hit = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIGEST_LENGTH: begin n_dl = i_cfg_data; cfg_hit = 1'b1; end
                CFG_KEY_LENGTH:    begin n_kl = i_cfg_data; cfg_hit = 1'b1; end
                default: ;
            endcase
        end
        ed = (n_dl == 7'd0) ? 7'd1 : ((n_dl > 7'd64) ? 7'd64 : n_dl);
        ek = (n_kl > 7'd64) ? 7'd64 : n_kl;
        param = blk2_pkg::PARAM_BASE ^ {49'd0, ek, 8'd0} ^ {57'd0, ed};
    end

    // current digest count, clamped
    logic [6:0] cur_ed;
    assign cur_ed = (r_dl == 7'd0) ? 7'd1 : ((r_dl > 7'd64) ? 7'd64 : r_dl);

    // half-mix datapath
    logic [3:0] rnd, rr, ia, ib, ic, id, mi;
    logic [2:0] g;
    logic       half;
    logic [63:0] va, vb, vc, vd, mw, mmask, na, nb, nc, nd, xd, xb;
    always_comb begin
        rnd  = r_step[7:4];
        rr   = (rnd >= 4'd10) ? rnd - 4'd10 : rnd;
        g    = r_step[3:1];
        half = r_step[0];
        ia = blk2_pkg::MIX_POS[g][0];
        ib = blk2_pkg::MIX_POS[g][1];
        ic = blk2_pkg::MIX_POS[g][2];
        id = blk2_pkg::MIX_POS[g][3];
        mi = blk2_pkg::SIGMA[rr][{g, half}];
        for (int b = 0; b < 8; b++) begin
            mmask[8*b +: 8] = ({1'b0, mi, 3'(b)} < r_fill) ? 8'hFF : 8'h00;
        end
        mw = r_buf[mi] & mmask;
        va = r_v[ia];
        vb = r_v[ib];
        vc = r_v[ic];
        vd = r_v[id];
        na = va + vb + mw;
        xd = vd ^ na;
        nd = half ? {xd[15:0], xd[63:16]} : {xd[31:0], xd[63:32]};
        nc = vc + nd;
        xb = vb ^ nc;
        nb = half ? {xb[62:0], xb[63]} : {xb[23:0], xb[63:24]};
    end

    logic take, emit_go;
    assign take = (r_state == ST_IDLE) && i_item_valid && !cfg_hit;
    assign o_item_pop = take;
    assign emit_go = (r_state == ST_EMIT) && (!r_ov || i_ready);

    // control, chain words, counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_dl    <= 7'd64;
            r_kl    <= 7'd0;
            r_fill  <= '0;
            r_cnt   <= '0;
            r_step  <= '0;
            r_final <= 1'b0;
            r_eidx  <= '0;
            r_ov    <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= blk2_pkg::IV[i] ^ ((i == 0) ? (blk2_pkg::PARAM_BASE ^ 64'd64) : 64'd0);
            end
        end else begin
            r_dl <= n_dl;
            r_kl <= n_kl;
            if (o_valid && i_ready && !(emit_go && !cfg_hit)) r_ov <= 1'b0;
            if (cfg_hit) begin
                // restart from new configuration
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= blk2_pkg::IV[i] ^ ((i == 0) ? param : 64'd0);
                end
                r_cnt  <= '0;
                r_fill <= '0;
            end else begin
                unique case (r_state)
                    ST_IDLE: begin
                        if (take) begin
                            if (i_item.func == blk2_pkg::FUNC_FINISH) begin
                                r_cnt   <= r_cnt + {120'd0, r_fill};
                                r_final <= 1'b1;
                                r_state <= ST_INIT;
                            end else if (r_fill == BLOCK_BYTES) begin
                                r_cnt   <= r_cnt + {120'd0, BLOCK_BYTES};
                                r_final <= 1'b0;
                                r_state <= ST_INIT;
                            end else begin
                                r_fill <= r_fill + 8'd1;
                            end
                        end
                    end
                    ST_INIT: begin
                        r_step  <= '0;
                        r_state <= ST_COMP;
                    end
                    ST_COMP: begin
                        r_step <= r_step + 8'd1;
                        if (r_step == LAST_STEP) r_state <= ST_FOLD;
                    end
                    ST_FOLD: begin
                        for (int i = 0; i < 8; i++) begin
                            r_h[i] <= r_h[i] ^ r_v[i] ^ r_v[i+8];
                        end
                        if (r_final) begin
                            r_eidx  <= '0;
                            r_state <= ST_EMIT;
                        end else begin
                            r_fill  <= 8'd1;
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_EMIT: begin
                        if (emit_go) begin
                            r_ov    <= 1'b1;
                            r_obyte <= r_h[r_eidx[5:3]][{r_eidx[2:0], 3'b000} +: 8];
                            r_oidx  <= r_eidx;
                            r_olast <= ({1'b0, r_eidx} + 7'd1 == cur_ed);
                            r_eidx  <= r_eidx + 6'd1;
                            if ({1'b0, r_eidx} + 7'd1 == cur_ed) begin
                                for (int i = 0; i < 8; i++) begin
                                    r_h[i] <= blk2_pkg::IV[i] ^ ((i == 0) ? param : 64'd0);
                                end
                                r_cnt   <= '0;
                                r_fill  <= '0;
                                r_state <= ST_IDLE;
                            end
                        end
                    end
                    default: r_state <= ST_IDLE;
                endcase
            end
        end
    end

    // hold pending byte across a block compression
    always_ff @(posedge i_clk) begin
        if (take && i_item.func == blk2_pkg::FUNC_ABSORB) r_pend <= i_item.data_byte;
    end

    // write block buffer
    always_ff @(posedge i_clk) begin
        if (take && i_item.func == blk2_pkg::FUNC_ABSORB && r_fill != BLOCK_BYTES) begin
            r_buf[r_fill[6:3]][{r_fill[2:0], 3'b000} +: 8] <= i_item.data_byte;
        end else if (r_state == ST_FOLD && !r_final && !cfg_hit) begin
            r_buf[0][7:0] <= r_pend;
        end
    end

    // load and mix the work vector
    always_ff @(posedge i_clk) begin
        if (r_state == ST_INIT) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            r_v[8]  <= blk2_pkg::IV[0];
            r_v[9]  <= blk2_pkg::IV[1];
            r_v[10] <= blk2_pkg::IV[2];
            r_v[11] <= blk2_pkg::IV[3];
            r_v[12] <= blk2_pkg::IV[4] ^ r_cnt[63:0];
            r_v[13] <= blk2_pkg::IV[5] ^ r_cnt[127:64];
            r_v[14] <= blk2_pkg::IV[6] ^ (r_final ? blk2_pkg::FINAL_MASK : 64'd0);
            r_v[15] <= blk2_pkg::IV[7];
        end else if (r_state == ST_COMP) begin
            r_v[ia] <= na;
            r_v[ib] <= nb;
            r_v[ic] <= nc;
            r_v[id] <= nd;
        end
    end

    assign o_valid       = r_ov;
    assign o_digest_byte = r_obyte;
    assign o_byte_index  = r_oidx;
    assign o_last_byte   = r_olast;

    `BLK2_ASSERT(a_fill_bound, r_fill <= BLOCK_BYTES, "fill level above block size")
    `BLK2_ASSERT(a_emit_final, (r_state == ST_EMIT) |-> r_final, "emit without final block")
    `BLK2_ASSERT(a_step_bound, (r_state == ST_COMP) |-> (r_step <= LAST_STEP), "mix step out of range")
endmodule

[hw/rtl/blake2b_hash_engine.sv]
// BLAKE2b hash engine for a byte stream: absorbs one byte per cycle from an input
// queue while idle and not being configured; crossing a 128-byte block boundary
// stalls it for a load, 192 half-mix steps of the shared mixing unit and a fold;
// a finish item does the same, then sends the digest bytes out of the output
// register as i_ready allows. Depends on blk2_pkg, blk2_front and blk2_core.
`timescale 1ns / 1ps
module blake2b_hash_engine #(
    parameter int QUEUE_DEPTH = blk2_pkg::QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [6:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_func,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_digest_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last_byte
);
    blk2_pkg::t_item item;
    logic item_valid, item_pop;

    blk2_front #(.DEPTH(QUEUE_DEPTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_func, .i_data_byte,
        .o_item(item), .o_item_valid(item_valid), .i_item_pop(item_pop)
    );

    blk2_core u_core (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_item(item), .i_item_valid(item_valid), .o_item_pop(item_pop),
        .o_valid, .i_ready, .o_digest_byte, .o_byte_index, .o_last_byte
    );
endmodule
